@@ hdl/pru_pkg.sv @@
// Shared types and constants for the PNG row unfilter block.
// Depends on nothing; every other file of the block but pru_ram uses it.
`default_nettype none

package pru_pkg;

  localparam int BYTE_W          = 8;
  localparam int MAX_ROW_BYTES   = 4096;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int QUEUE_DEPTH     = 4;

  // configuration register widths
  localparam int COLS_W    = 13;
  localparam int BPPCFG_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = (COLS_W > BPPCFG_W) ? COLS_W : BPPCFG_W;

  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
  localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int SEL_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PROD_W = COLS_W + BPP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd1;

  localparam logic [BYTE_W-1:0] FILT_NONE = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB  = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP   = 8'd2;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ADD_SUB,
    OP_ADD_UP,
    OP_BAD
  } op_t;

  // one classified data byte, handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [SEL_W-1:0]  sel;
    logic              last;
  } pru_item_t;

endpackage

`default_nettype wire

@@ hdl/pru_if.sv @@
// Valid/ready channel interfaces for the input bytes and the decoded results.
// Depends on pru_pkg for the byte width.
`default_nettype none

interface pru_in_if;
  logic                      valid;
  logic                      ready;
  logic [pru_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pru_out_if;
  logic                      valid;
  logic                      ready;
  logic [pru_pkg::BYTE_W-1:0] out_byte;
  logic                      row_end;
  logic                      bad_filter;

  modport source (output valid, output out_byte, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input out_byte, input row_end, input bad_filter,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/pru_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Read during a write to the same address returns the old contents.
`default_nettype none

module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/pru_front.sv @@
// Front end: configuration registers, row tracking and classification of each byte.
// Depends on pru_pkg and pru_in_if; feeds pru_queue.
`default_nettype none

module pru_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pru_pkg::CFG_DAT_W-1:0]  cfg_data,
  pru_in_if.sink                              in_ch,
  input  wire logic                           q_full,
  output      logic                           q_push,
  output      pru_pkg::pru_item_t             q_item
);

  import pru_pkg::*;

  logic [COLS_W-1:0]   columns_r;
  logic [BPPCFG_W-1:0] bpp_r;
  logic                filt_exp_r, filt_exp_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_W-1:0]   filter_r, filter_nxt;
  logic                first_row_r, first_row_nxt;

  logic [BPP_W-1:0]  eff_bpp;
  logic [COLS_W-1:0] eff_cols;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  row_len;
  logic              accept;
  logic              last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLS_W'(1);
      bpp_r     <= BPPCFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS:         columns_r <= cfg_data[COLS_W-1:0];
        CFG_BYTES_PER_PIXEL: bpp_r     <= cfg_data[BPPCFG_W-1:0];
      endcase
    end
  end

  // clamp the configuration into its usable range
  always_comb begin
    if (bpp_r == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (32'(bpp_r) > MAX_PIXEL_BYTES) begin
      eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = BPP_W'(bpp_r);
    end
    eff_cols = (columns_r == '0) ? COLS_W'(1) : columns_r;
    prod     = PROD_W'(eff_cols) * PROD_W'(eff_bpp);
    row_len  = (32'(prod) > MAX_ROW_BYTES) ? POS_W'(MAX_ROW_BYTES) : POS_W'(prod);
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign last        = (POS_W'(idx_r) + POS_W'(1)) >= row_len;

  always_comb begin
    q_item.data_byte = in_ch.data_byte;
    q_item.addr      = idx_r;
    q_item.sel       = SEL_W'(eff_bpp - BPP_W'(1));
    q_item.last      = last;
    priority if (filter_r == FILT_NONE) begin
      q_item.op = OP_PASS;
    end else if (filter_r == FILT_SUB) begin
      q_item.op = (32'(idx_r) >= 32'(eff_bpp)) ? OP_ADD_SUB : OP_PASS;
    end else if (filter_r == FILT_UP) begin
      q_item.op = first_row_r ? OP_PASS : OP_ADD_UP;
    end else begin
      q_item.op = OP_BAD;
    end
  end

  assign q_push = accept && !filt_exp_r;

  always_comb begin
    filt_exp_nxt  = filt_exp_r;
    idx_nxt       = idx_r;
    filter_nxt    = filter_r;
    first_row_nxt = first_row_r;
    if (accept) begin
      if (filt_exp_r) begin
        filter_nxt   = in_ch.data_byte;
        filt_exp_nxt = 1'b0;
        idx_nxt      = '0;
      end else if (last) begin
        filt_exp_nxt  = 1'b1;
        first_row_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_exp_r  <= 1'b1;
      idx_r       <= '0;
      filter_r    <= '0;
      first_row_r <= 1'b1;
    end else begin
      filt_exp_r  <= filt_exp_nxt;
      idx_r       <= idx_nxt;
      filter_r    <= filter_nxt;
      first_row_r <= first_row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pru_queue.sv @@
// Short FIFO of classified bytes between the front end and the back end.
// Depends on pru_pkg.
`default_nettype none

module pru_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire pru_pkg::pru_item_t push_item,
  input  wire logic               pop,
  output      logic               q_valid,
  output      logic               q_full,
  output      pru_pkg::pru_item_t head_item
);

  import pru_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  pru_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign q_valid   = count_r != '0;
  assign q_full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pru_back.sv @@
// Back end: line store read, byte reconstruction, history of recent bytes, output register.
// Depends on pru_pkg, pru_ram and pru_out_if.
`default_nettype none

module pru_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire pru_pkg::pru_item_t head_item,
  output      logic               q_pop,
  pru_out_if.source               out_ch
);

  import pru_pkg::*;

  logic              s2_valid_r, s2_valid_nxt;
  pru_item_t         s2_item_r;
  logic              fwd_r;
  logic [BYTE_W-1:0] fwd_byte_r;
  logic [BYTE_W-1:0] recent_r [MAX_PIXEL_BYTES];

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              row_end_r;
  logic              bad_r;

  logic [BYTE_W-1:0] above_rd;
  logic [BYTE_W-1:0] above;
  logic [BYTE_W-1:0] dec;
  logic              fin;

  // finish the held byte when the output register is free or drains this cycle
  assign fin   = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop = q_valid && (!s2_valid_r || fin);

  pru_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (fin),
    .waddr (s2_item_r.addr),
    .wdata (dec),
    .re    (q_pop),
    .raddr (head_item.addr),
    .rdata (above_rd)
  );

  // the RAM returns old data when the byte above is written in the same cycle
  assign above = fwd_r ? fwd_byte_r : above_rd;

  always_comb begin
    unique case (s2_item_r.op)
      OP_PASS:    dec = s2_item_r.data_byte;
      OP_ADD_SUB: dec = s2_item_r.data_byte + recent_r[s2_item_r.sel];
      OP_ADD_UP:  dec = s2_item_r.data_byte + above;
      OP_BAD:     dec = '0;
      default:    dec = '0;
    endcase
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (q_pop) begin
      s2_valid_nxt = 1'b1;
    end else if (fin) begin
      s2_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_item_r  <= head_item;
      fwd_r      <= fin && (s2_item_r.addr == head_item.addr);
      fwd_byte_r <= dec;
    end
    if (fin) begin
      out_byte_r <= dec;
      row_end_r  <= s2_item_r.last;
      bad_r      <= s2_item_r.op == OP_BAD;
    end
  end

  // history of decoded bytes, newest in slot zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        recent_r[i] <= '0;
      end
    end else if (fin) begin
      recent_r[0] <= dec;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        recent_r[i] <= recent_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.row_end    = row_end_r;
  assign out_ch.bad_filter = bad_r;

endmodule

`default_nettype wire

@@ hdl/png_row_unfilter.sv @@
// PNG row unfilter (None, Sub, Up). Takes one stream byte per cycle on in_ch, sustained
// while out_ch takes its results, whether it is a row's filter byte (no result) or a data
// byte (one result on out_ch). A data byte passes through the queue, then the back end's
// stage where the registered line store read lands, then the output register, where it
// holds until taken. The rate is set by the line store, which takes one read and one
// write per cycle, and by the back end finishing one byte per cycle while out_ch is ready.
// The line store needs no clearing pass if Up bytes use its entries only after a previous
// row wrote them; the user must keep to this, the block itself does not enforce it.
// Configuration takes effect on the next byte; write it only while the block is idle.
`default_nettype none

module png_row_unfilter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::CFG_DAT_W-1:0] cfg_data,
  pru_in_if.sink                             in_ch,
  pru_out_if.source                          out_ch
);

  import pru_pkg::*;

  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  logic      q_full;
  pru_item_t push_item;
  pru_item_t head_item;

  pru_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  pru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head_item (head_item)
  );

  pru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head_item (head_item),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // an unsupported filter always yields a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_filter |-> out_ch.out_byte == '0)
    else $error("bad_filter beat with nonzero byte");

  // Sub only adds once a full pixel lies behind the byte
  a_sub_reach: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && push_item.op == OP_ADD_SUB |-> push_item.addr > ADDR_W'(push_item.sel))
    else $error("Sub classified inside the first pixel");

  // nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid && !q_valid)
    else $error("output or queue busy after reset");
`endif

endmodule

`default_nettype wire

@@ verif/pru_unfilter_checker.sv @@
`timescale 1ns / 1ps
// Passive checker for png_row_unfilter: watches the config port and both channels,
// decodes each accepted stream byte itself and compares the decoded beats that come out.
// Depends on pru_pkg and the pru_in_if / pru_out_if channel interfaces.
module pru_unfilter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pru_pkg::CFG_DAT_W-1:0] cfg_data,
  pru_in_if                             in_mon,
  pru_out_if                            out_mon,
  output int                            fail_count,
  output int                            pending,
  output int                            rows_closed,
  output int                            bad_bytes
);

  import pru_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              row_end;
    logic              bad_filter;
  } decoded_t;

  logic [BYTE_W-1:0]   line_above [MAX_ROW_BYTES];
  logic [BYTE_W-1:0]   recent [MAX_PIXEL_BYTES];
  logic [COLS_W-1:0]   columns_r;
  logic [BPPCFG_W-1:0] bpp_r;
  int                  row_pos;
  logic [BYTE_W-1:0]   row_filt;
  logic                in_first_row;
  decoded_t            decoded_q [$];
  int                  errs = 0;
  int                  n_rows = 0;
  int                  n_bad = 0;

  assign fail_count  = errs;
  assign rows_closed = n_rows;
  assign bad_bytes   = n_bad;

  task automatic unfilter_byte(input logic [BYTE_W-1:0] b);
    int       pix;
    int       len;
    int       idx;
    decoded_t d;
    if (row_pos == 0) begin
      row_filt = b;
      row_pos  = 1;
      return;
    end
    pix = (bpp_r == 0) ? 1 : ((bpp_r > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(bpp_r));
    len = ((columns_r == 0) ? 1 : int'(columns_r)) * pix;
    if (len > MAX_ROW_BYTES) len = MAX_ROW_BYTES;
    idx = row_pos - 1;
    d.bad_filter = 1'b0;
    case (row_filt)
      FILT_NONE: d.out_byte = b;
      FILT_SUB:  d.out_byte = (idx >= pix) ? b + recent[pix-1] : b;
      FILT_UP:   d.out_byte = in_first_row ? b : b + line_above[idx];
      default: begin
        d.out_byte   = '0;
        d.bad_filter = 1'b1;
        n_bad++;
      end
    endcase
    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0]       = d.out_byte;
    line_above[idx] = d.out_byte;
    d.row_end = (idx + 1 >= len);
    if (d.row_end) begin
      row_pos      = 0;
      in_first_row = 1'b0;
      n_rows++;
    end else begin
      row_pos++;
    end
    decoded_q.push_back(d);
  endtask

  task automatic check_beat(input logic [BYTE_W-1:0] got_byte, input logic got_end,
                            input logic got_bad);
    decoded_t want;
    if (decoded_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("[%0t] unexpected beat: byte %02h row_end %b bad_filter %b",
                 $realtime, got_byte, got_end, got_bad);
      return;
    end
    want = decoded_q.pop_front();
    if (got_byte !== want.out_byte || got_end !== want.row_end ||
        got_bad !== want.bad_filter) begin
      errs++;
      if (errs <= 10)
        $display("[%0t] mismatch: got byte %02h row_end %b bad_filter %b, want %02h %b %b",
                 $realtime, got_byte, got_end, got_bad,
                 want.out_byte, want.row_end, want.bad_filter);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      columns_r    = 1;
      bpp_r        = 1;
      row_pos      = 0;
      row_filt     = FILT_NONE;
      in_first_row = 1'b1;
      foreach (recent[k]) recent[k] = '0;
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLUMNS:         columns_r = cfg_data[COLS_W-1:0];
          CFG_BYTES_PER_PIXEL: bpp_r     = cfg_data[BPPCFG_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) unfilter_byte(in_mon.data_byte);
      if (out_mon.valid && out_mon.ready)
        check_beat(out_mon.out_byte, out_mon.row_end, out_mon.bad_filter);
    end
    pending <= decoded_q.size();
  end

endmodule

@@ verif/tb_png_row_unfilter.sv @@
`timescale 1ns / 1ps
// Top of the png_row_unfilter testbench: clock, reset, config writes, stream stimulus
// and output back-pressure; pru_unfilter_checker does the decoding and comparing.
// Depends on pru_pkg, the channel interfaces, png_row_unfilter and the checker.
module tb_png_row_unfilter;
  import pru_pkg::*;

  localparam logic [BYTE_W-1:0] FILT_BAD_LO = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_BAD_HI = 8'hFF;
  localparam int                COLS_MAX    = 8191;
  localparam int                BPP_MAX     = 15;
  localparam int                DRAIN_CYC   = 6;

  typedef enum int {WR_BOTH, WR_COLS, WR_BPP} cfg_sel_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int fail_count, pending, rows_closed, bad_bytes;

  // stream position as the block will see it, used to keep Up rows legal
  int                gen_cols, gen_bpp, gen_pos, gen_first, line_hw;
  logic [BYTE_W-1:0] gen_filter;
  int                n_bytes = 0;
  int                n_writes = 0;
  bit                quiet;

  pru_in_if  in_ch ();
  pru_out_if out_ch ();

  png_row_unfilter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pru_unfilter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .rows_closed (rows_closed),
    .bad_bytes   (bad_bytes)
  );

  always #4 clk = ~clk;

  initial begin
    #25_000_000;
    $display("FAIL png_row_unfilter");
    $finish;
  end

  function automatic int row_len(input int c, input int b);
    int len;
    if (c == 0) c = 1;
    if (b == 0) b = 1;
    if (b > MAX_PIXEL_BYTES) b = MAX_PIXEL_BYTES;
    len = c * b;
    return (len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : len;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_filter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return FILT_NONE;
    if (r < 56) return FILT_SUB;
    // Up only where every byte above has been written
    if (r < 84) return (gen_first != 0 || row_len(gen_cols, gen_bpp) <= line_hw) ?
                       FILT_UP : FILT_SUB;
    return BYTE_W'($urandom_range(FILT_BAD_LO, FILT_BAD_HI));
  endfunction

  function automatic int pick_cols();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 11) return COLS_MAX;
    if (r < 14) return MAX_ROW_BYTES;
    if (r < 80) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  function automatic int pick_bpp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return BPP_MAX;
    if (r < 30) return MAX_PIXEL_BYTES;
    return $urandom_range(1, BPP_MAX);
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stream_byte(input logic [BYTE_W-1:0] b);
    int idx;
    if (gen_pos == 0) begin
      gen_filter = b;
      gen_pos    = 1;
    end else begin
      idx = gen_pos - 1;
      if (idx + 1 > line_hw) line_hw = idx + 1;
      if (idx + 1 >= row_len(gen_cols, gen_bpp)) begin
        gen_pos   = 0;
        gen_first = 0;
      end else begin
        gen_pos++;
      end
    end
    n_bytes++;
    push_byte(b);
  endtask

  task automatic finish_row();
    while (gen_pos != 0) stream_byte(pick_data());
  endtask

  task automatic feed(input int n);
    repeat (n) stream_byte((gen_pos == 0) ? pick_filter() : pick_data());
  endtask

  // drop valid, let every expected beat drain, then cover any trailing filter byte
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DAT_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_writes++;
  endtask

  task automatic reconfigure(input int new_cols, input int new_bpp, input cfg_sel_t sel);
    int c, b, nl, nxt, last_idx;
    c  = (sel == WR_BPP) ? gen_cols : new_cols;
    b  = (sel == WR_COLS) ? gen_bpp : new_bpp;
    nl = row_len(c, b);
    // an Up row that would run past the written part of the line store: close it first
    if (gen_pos != 0 && gen_filter == FILT_UP && gen_first == 0) begin
      nxt      = gen_pos - 1;
      last_idx = (nxt + 1 >= nl) ? nxt : nl - 1;
      if (last_idx >= line_hw) finish_row();
    end
    wait_idle();
    if (sel != WR_BPP) begin
      write_reg(CFG_COLUMNS, new_cols);
      gen_cols = new_cols;
    end
    if (sel != WR_COLS) begin
      write_reg(CFG_BYTES_PER_PIXEL, new_bpp);
      gen_bpp = new_bpp;
    end
  endtask

  initial begin : sink_side
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        if ($urandom_range(0, 3) == 0) stall = idle_len();
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : stimulus
    int rand_bytes;
    int mark;
    rand_bytes      = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_COLUMNS;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    quiet           = 1'b0;
    gen_cols        = 1;
    gen_bpp         = 1;
    gen_pos         = 0;
    gen_first       = 1;
    line_hw         = 0;
    gen_filter      = FILT_NONE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, one-byte rows: every filter kind and the byte extremes
    stream_byte(FILT_NONE);   stream_byte(8'hFF);
    stream_byte(FILT_UP);     stream_byte(8'h01);  // wraps to zero
    stream_byte(FILT_SUB);    stream_byte(8'h80);
    stream_byte(FILT_BAD_LO); stream_byte(8'h55);
    stream_byte(FILT_BAD_HI); stream_byte(8'h00);
    stream_byte(FILT_UP);     stream_byte(8'h7F);  // adds the forced zero above
    // zero columns and zero bytes per pixel read as one
    reconfigure(0, 0, WR_BOTH);
    stream_byte(FILT_SUB);    stream_byte(8'hFF);
    // six-byte rows: Sub looks back one pixel and wraps
    reconfigure(2, 3, WR_BOTH);
    stream_byte(FILT_SUB);
    stream_byte(8'h10); stream_byte(8'h20); stream_byte(8'h30);
    stream_byte(8'hF0); stream_byte(8'hF0); stream_byte(8'hF0);
    // shrink the row mid-way: the next data byte must close it
    stream_byte(FILT_NONE);   stream_byte(8'hA5); stream_byte(8'h5A);
    reconfigure(0, 1, WR_BPP);
    stream_byte(8'hC3);

    while (rand_bytes < 600) begin
      mark  = n_bytes;
      quiet = ($urandom_range(0, 3) == 0);
      reconfigure(pick_cols(), pick_bpp(), cfg_sel_t'($urandom_range(0, 2)));
      feed($urandom_range(10, 80));
      rand_bytes += n_bytes - mark;
    end

    wait_idle();
    $display("Run covered %0d stream bytes and %0d register writes, mid-row resizes incl.",
             n_bytes, n_writes);
    $display("%0d rows closed, %0d bytes from unsupported filters, %0d mismatches.",
             rows_closed, bad_bytes, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS png_row_unfilter");
    end else begin
      $display("FAIL png_row_unfilter");
    end
    $finish;
  end

endmodule
